// ===== hdl/nlp_pkg.sv =====
`timescale 1ns / 1ps

package nlp_pkg;

	// operation codes on the func field
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_ADV  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_wr;
		logic rd_issue;
		logic adv_start;
		logic scan;
		logic s1_cmp;
		logic s2_init;
		logic s2_cmp;
		logic wr_k;
		logic wr_l;
		logic rv_rd_lo;
		logic rv_rd_hi;
		logic rv_wr_lo;
		logic rv_wr_hi;
		logic post_rd;
		logic post_adv;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic n_lt2;
		logic scan_done;
		logic found_any;
		logic rv_first;
		logic rv_more2;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/nlp_ctrl.sv =====
`timescale 1ns / 1ps

module nlp_ctrl import nlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] func,
	input  sts_t       sts,
	output logic       in_stall,
	output cmd_t       cmd
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b000000000001,
		ST_S1       = 12'b000000000010,
		ST_S2_INIT  = 12'b000000000100,
		ST_S2       = 12'b000000001000,
		ST_SWK      = 12'b000000010000,
		ST_SWL      = 12'b000000100000,
		ST_RV_A     = 12'b000001000000,
		ST_RV_B     = 12'b000010000000,
		ST_RV_C     = 12'b000100000000,
		ST_RV_D     = 12'b001000000000,
		ST_POST_RD  = 12'b010000000000,
		ST_POST_ADV = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// new beats are taken only between operations
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_LOAD: cmd.load_wr = 1'b1;
						FUNC_READ: begin
							cmd.rd_issue = 1'b1;
							state_d      = ST_POST_RD;
						end
						FUNC_ADV: begin
							cmd.adv_start = 1'b1;
							state_d       = sts.n_lt2 ? ST_POST_ADV : ST_S1;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_S1: begin
				cmd.scan   = 1'b1;
				cmd.s1_cmp = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.found_any ? ST_S2_INIT : ST_POST_ADV;
				end
			end
			ST_S2_INIT: begin
				cmd.s2_init = 1'b1;
				state_d     = ST_S2;
			end
			ST_S2: begin
				cmd.scan   = 1'b1;
				cmd.s2_cmp = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_SWK;
				end
			end
			ST_SWK: begin
				cmd.wr_k = 1'b1;
				state_d  = ST_SWL;
			end
			ST_SWL: begin
				cmd.wr_l = 1'b1;
				state_d  = sts.rv_first ? ST_RV_A : ST_POST_ADV;
			end
			ST_RV_A: begin
				cmd.rv_rd_lo = 1'b1;
				state_d      = ST_RV_B;
			end
			ST_RV_B: begin
				cmd.rv_rd_hi = 1'b1;
				state_d      = ST_RV_C;
			end
			ST_RV_C: begin
				cmd.rv_wr_lo = 1'b1;
				state_d      = ST_RV_D;
			end
			ST_RV_D: begin
				// also reads the next low key, which is used when another pair remains
				cmd.rv_wr_hi = 1'b1;
				state_d      = sts.rv_more2 ? ST_RV_B : ST_POST_ADV;
			end
			ST_POST_RD: begin
				if (sts.out_free) begin
					cmd.post_rd = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_POST_ADV: begin
				if (sts.out_free) begin
					cmd.post_adv = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/nlp_dpath.sv =====
`timescale 1ns / 1ps

module nlp_dpath import nlp_pkg::*; #(
	parameter int MAX_ELEMENTS = 8,
	parameter int KEY_BITS     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic [2:0]  slot,
	input  logic [63:0] key_in,
	input  logic        out_stall,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	output logic        result_kind,
	output logic        advanced,
	output logic [63:0] key_out
);

	localparam int            IW       = $clog2(MAX_ELEMENTS);
	localparam logic [IW-1:0] LAST_MAX = IW'(MAX_ELEMENTS - 1);

	// key store
	logic [KEY_BITS-1:0] mem [MAX_ELEMENTS];
	logic [KEY_BITS-1:0] rdata_q;
	logic [KEY_BITS-1:0] wdata;
	logic [IW-1:0]       raddr, waddr;
	logic                re, we;

	logic [3:0]          count_q;
	logic                slot_ok, slot_ok_q;
	logic [IW-1:0]       slot_idx, last_n, last_q;
	logic [IW-1:0]       ptr_q, ridx_s1, k_q, l_q, lo_q, hi_q;
	logic                rvld_s1, iss_done_q, issue;
	logic [KEY_BITS-1:0] prev_q, kkey_q, lkey_q, tmp_q;
	logic                found_q, hit1, hit2;
	logic                out_vld_q, out_kind_q, out_adv_q;
	logic [63:0]         out_key_q;

	// slot decode and effective length
	assign slot_ok  = (int'(slot) < MAX_ELEMENTS);
	assign slot_idx = IW'(slot);
	assign last_n   = (int'(count_q) > MAX_ELEMENTS) ? LAST_MAX : IW'(int'(count_q) - 1);

	// scan read issue
	assign issue = cmd.scan & ~iss_done_q;

	// read port address
	always_comb begin
		re    = cmd.rd_issue | issue | cmd.rv_rd_lo | cmd.rv_rd_hi | cmd.rv_wr_hi;
		raddr = ptr_q;
		if (cmd.rd_issue) begin
			raddr = slot_idx;
		end else if (cmd.rv_rd_lo) begin
			raddr = lo_q;
		end else if (cmd.rv_rd_hi) begin
			raddr = hi_q;
		end else if (cmd.rv_wr_hi) begin
			raddr = lo_q + 1'b1;
		end
	end

	// write port
	always_comb begin
		we    = 1'b0;
		waddr = slot_idx;
		wdata = key_in[KEY_BITS-1:0];
		if (cmd.load_wr) begin
			we = slot_ok;
		end else if (cmd.wr_k) begin
			we    = 1'b1;
			waddr = k_q;
			wdata = lkey_q;
		end else if (cmd.wr_l) begin
			we    = 1'b1;
			waddr = l_q;
			wdata = kkey_q;
		end else if (cmd.rv_wr_lo) begin
			we    = 1'b1;
			waddr = lo_q;
			wdata = rdata_q;
		end else if (cmd.rv_wr_hi) begin
			we    = 1'b1;
			waddr = hi_q;
			wdata = tmp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// ascent search and successor search compares
	assign hit1 = cmd.s1_cmp & rvld_s1 & (ridx_s1 != '0) & (prev_q < rdata_q);
	assign hit2 = cmd.s2_cmp & rvld_s1 & (rdata_q > kkey_q);

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			slot_ok_q <= slot_ok;
		end
		if (cmd.adv_start) begin
			found_q <= 1'b0;
			last_q  <= last_n;
			ptr_q   <= '0;
		end
		if (issue) begin
			ridx_s1 <= ptr_q;
			if (ptr_q != last_q) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
		if (cmd.s1_cmp & rvld_s1) begin
			prev_q <= rdata_q;
		end
		if (hit1) begin
			k_q     <= ridx_s1 - 1'b1;
			kkey_q  <= prev_q;
			found_q <= 1'b1;
		end
		if (cmd.s2_init) begin
			ptr_q <= k_q + 1'b1;
		end
		if (hit2) begin
			l_q    <= ridx_s1;
			lkey_q <= rdata_q;
		end
		if (cmd.wr_l) begin
			lo_q <= k_q + 1'b1;
			hi_q <= last_q;
		end
		if (cmd.rv_rd_hi) begin
			tmp_q <= rdata_q;
		end
		if (cmd.rv_wr_hi) begin
			lo_q <= lo_q + 1'b1;
			hi_q <= hi_q - 1'b1;
		end
		// result beat payload
		if (cmd.post_rd) begin
			out_kind_q <= KIND_DATA;
			out_adv_q  <= 1'b0;
			out_key_q  <= slot_ok_q ? 64'(rdata_q) : '0;
		end else if (cmd.post_adv) begin
			out_kind_q <= KIND_STATUS;
			out_adv_q  <= found_q;
			out_key_q  <= '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			iss_done_q <= 1'b0;
			rvld_s1    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			if (cmd.adv_start | cmd.s2_init) begin
				iss_done_q <= 1'b0;
			end else if (issue && ptr_q == last_q) begin
				iss_done_q <= 1'b1;
			end
			rvld_s1 <= issue;
			if (cmd.post_rd | cmd.post_adv) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// status
	assign sts.n_lt2     = (count_q < 4'd2);
	assign sts.scan_done = rvld_s1 & (ridx_s1 == last_q);
	assign sts.found_any = found_q | hit1;
	assign sts.rv_first  = (int'(k_q) + 1 < int'(last_q));
	assign sts.rv_more2  = (int'(lo_q) + 2 < int'(hi_q));
	assign sts.out_free  = ~out_vld_q | ~out_stall;

	assign out_valid   = out_vld_q;
	assign result_kind = out_kind_q;
	assign advanced    = out_adv_q;
	assign key_out     = out_key_q;

endmodule

// ===== hdl/next_lexicographic_permutation_top.sv =====
`timescale 1ns / 1ps
// Next lexicographic permutation over a small key store.
// Input channel (in_valid/in_stall, fields func, slot, key_in): a beat is taken
// when in_valid is high and in_stall low. func load writes key_in to a slot,
// read returns the stored key, advance permutes the first element_count keys.
// Output channel (out_valid/out_stall, fields result_kind, advanced, key_out):
// one beat per read or advance, none for a load or an unused code.
// element_count is written through cfg_wr_en/cfg_wr_data while idle; the block
// does not enforce this, the user must. A load is done at its accept edge; a
// read reads the store at accept and raises out_valid after its post step. An
// advance runs on the single-read, single-write store: an ascent scan for k, a
// setup step, a successor scan, two swap writes, a low read, then a high read,
// low write and high write per reversed pair, then a post step; no ascent posts
// after the first scan, n below 2 posts at once. One operation is in flight at a
// time; in_stall is high while it runs, so the next beat is taken the cycle
// after the post at the earliest. The result sits in an output register, so a
// new beat is taken while an old result waits; a stalled receiver only holds a
// finished operation in its post step. Reset clears element_count and all
// control state; store contents are undefined until loaded.
module next_lexicographic_permutation_top import nlp_pkg::*; #(
	parameter int MAX_ELEMENTS = 8,
	parameter int KEY_BITS     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [2:0]  slot,
	input  logic [63:0] key_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic        advanced,
	output logic [63:0] key_out
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	nlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// key store and compare logic
	nlp_dpath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.KEY_BITS     (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.slot        (slot),
		.key_in      (key_in),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.advanced    (advanced),
		.key_out     (key_out)
	);

`ifndef ASSERT_OFF
	// the two swap writes always come back to back
	a_swap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_k |=> cmd.wr_l)
		else $error("swap of k and l not completed");

	// an accepted advance holds off the next beat
	a_adv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && func == FUNC_ADV) |=> in_stall)
		else $error("input taken during advance");

	// low reverse write follows the high reverse read and writes the key it read
	a_rv_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rv_wr_lo |-> $past(cmd.rv_rd_hi))
		else $error("reverse write out of order");

	// a result beat appears only after a post command
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.post_rd || cmd.post_adv))
		else $error("result beat without post");
`endif

endmodule

// ===== dv/next_lexicographic_permutation_top_tb.sv =====
`timescale 1ns / 1ps

module next_lexicographic_permutation_top_tb import nlp_pkg::*;;

	localparam int SLOTS         = 8;
	localparam int TARGET_OPS    = 950;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct {
		logic [1:0]  op;
		logic [2:0]  idx;
		logic [63:0] key;
	} op_item_t;

	typedef struct {
		logic        kind;
		logic        adv;
		logic [63:0] key;
	} outcome_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [3:0]  cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  func        = FUNC_NONE;
	logic [2:0]  slot        = '0;
	logic [63:0] key_in      = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        result_kind;
	logic        advanced;
	logic [63:0] key_out;

	// mirror of the key store and the permutation length
	logic [63:0] key_mirror [SLOTS];
	logic [3:0]  count_mirror = '0;

	op_item_t         op_backlog[$];
	outcome_t         awaited_outcomes[$];
	op_item_t         tx_item;
	outcome_t         rx_want;
	logic [SLOTS-1:0] slot_loaded = '0;
	logic [63:0]      alphabet [SLOTS];
	int               alpha_size = 1;
	int               stim_ops   = 0;
	int               mismatches = 0;
	int               cycles     = 0;
	int               tx_wait    = 0;
	int               tx_calm    = 0;
	int               rx_wait    = 0;
	int               rx_calm    = 0;

	next_lexicographic_permutation_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.slot        (slot),
		.key_in      (key_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.advanced    (advanced),
		.key_out     (key_out)
	);

	initial forever #4 clk = ~clk;

	// next permutation of the leading keys in the mirror, 1 if one existed
	function automatic logic permute_next();
		int          n, k, l, lo, hi;
		logic        found;
		logic [63:0] t;
		n = (count_mirror > SLOTS) ? SLOTS : int'(count_mirror);
		k = 0;
		l = 0;
		found = 1'b0;
		for (int i = 0; i + 1 < n; i++)
			if (key_mirror[i] < key_mirror[i + 1]) begin
				k = i;
				found = 1'b1;
			end
		if (!found)
			return 1'b0;
		for (int i = k + 1; i < n; i++)
			if (key_mirror[i] > key_mirror[k])
				l = i;
		t = key_mirror[k];
		key_mirror[k] = key_mirror[l];
		key_mirror[l] = t;
		lo = k + 1;
		hi = n - 1;
		while (lo < hi) begin
			t = key_mirror[lo];
			key_mirror[lo] = key_mirror[hi];
			key_mirror[hi] = t;
			lo++;
			hi--;
		end
		return 1'b1;
	endfunction

	// update the mirror for an accepted beat and queue the answer it owes
	function automatic void apply_op(logic [1:0] op, logic [2:0] idx, logic [63:0] key);
		case (op)
			FUNC_LOAD: key_mirror[idx] = key;
			FUNC_ADV:  awaited_outcomes.push_back('{KIND_STATUS, permute_next(), 64'd0});
			FUNC_READ: awaited_outcomes.push_back('{KIND_DATA, 1'b0, key_mirror[idx]});
			default: ;
		endcase
	endfunction

	// gap length: mostly short, a few long, with calm stretches of none
	function automatic int pick_pause(ref int calm);
		int r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic void flag_field(string name, logic [63:0] want, logic [63:0] got);
		mismatches++;
		$display("%0t ns: %s expected %h actual %h", $time, name, want, got);
	endfunction

	function automatic void push_op(logic [1:0] op, logic [2:0] idx, logic [63:0] key);
		op_backlog.push_back('{op, idx, key});
		if (op == FUNC_LOAD)
			slot_loaded[idx] = 1'b1;
		if (op != FUNC_NONE)
			stim_ops++;
	endfunction

	function automatic logic [63:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// input side: present the next pending beat after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_NONE;
			slot <= '0;
			key_in <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				apply_op(func, slot, key_in);
			if (tx_wait != 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (op_backlog.size() != 0) begin
				tx_item = op_backlog.pop_front();
				in_valid <= 1'b1;
				func <= tx_item.op;
				slot <= tx_item.idx;
				key_in <= tx_item.key;
				tx_wait = pick_pause(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random stall, check each accepted beat against the oldest answer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t ns: beat expected none actual kind %b advanced %b key %h",
						$time, result_kind, advanced, key_out);
				end else begin
					rx_want = awaited_outcomes.pop_front();
					if (result_kind !== rx_want.kind)
						flag_field("result_kind", 64'(rx_want.kind), 64'(result_kind));
					if (advanced !== rx_want.adv)
						flag_field("advanced", 64'(rx_want.adv), 64'(advanced));
					if (key_out !== rx_want.key)
						flag_field("key_out", rx_want.key, key_out);
				end
			end
			out_stall <= (rx_wait != 0);
			if (rx_wait != 0)
				rx_wait--;
			else
				rx_wait = pick_pause(rx_calm);
		end
	end

	// wait until no beat is pending or owed, then let an in-flight load finish
	task automatic settle();
		do begin
			while (op_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0)
				@(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
		end while (op_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0);
	endtask

	task automatic write_count(logic [3:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		count_mirror = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one setting: fresh keys from a small alphabet, then mostly advances and reads
	task automatic run_phase(int c);
		int n, span, len, r, s;
		n = (c > SLOTS) ? SLOTS : c;
		span = (n > 2) ? n : 3;
		alpha_size = ($urandom_range(0, 1) != 0) ? span : $urandom_range(1, span);
		for (int j = 0; j < alpha_size; j++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				alphabet[j] = '0;
			else if (r == 1)
				alphabet[j] = '1;
			else if (r == 2 && j > 0)
				alphabet[j] = {alphabet[0][63:8], 8'($urandom)};
			else
				alphabet[j] = rand_key();
		end
		for (int j = 0; j < SLOTS; j++)
			if (j < n || !slot_loaded[j] || $urandom_range(0, 9) < 3)
				push_op(FUNC_LOAD, 3'(j), alphabet[$urandom_range(0, alpha_size - 1)]);
		len = $urandom_range(40, 80);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				push_op(FUNC_ADV, 3'($urandom), rand_key());
			end else if (r < 80) begin
				do s = $urandom_range(0, SLOTS - 1); while (!slot_loaded[s]);
				push_op(FUNC_READ, 3'(s), rand_key());
			end else if (r < 92) begin
				if ($urandom_range(0, 4) == 0)
					push_op(FUNC_LOAD, 3'($urandom), rand_key());
				else
					push_op(FUNC_LOAD, 3'($urandom),
						alphabet[$urandom_range(0, alpha_size - 1)]);
			end else begin
				push_op(FUNC_NONE, 3'($urandom), rand_key());
			end
		end
	endtask

	initial begin : stimulus
		int plan [10] = '{1, 2, 3, 15, 8, 4, 5, 6, 7, 0};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme keys, every operation, short and oversized counts
		write_count(4'd0);
		push_op(FUNC_LOAD, 3'd0, 64'h0000_0000_0000_0000);
		push_op(FUNC_LOAD, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		push_op(FUNC_LOAD, 3'd2, 64'h8000_0000_0000_0000);
		push_op(FUNC_LOAD, 3'd3, 64'h0000_0000_0000_0001);
		push_op(FUNC_LOAD, 3'd4, 64'h7FFF_FFFF_FFFF_FFFF);
		push_op(FUNC_LOAD, 3'd5, 64'h5555_5555_5555_5555);
		push_op(FUNC_LOAD, 3'd6, 64'hAAAA_AAAA_AAAA_AAAA);
		push_op(FUNC_LOAD, 3'd7, 64'h6162_6300_0000_0000);
		for (int j = 0; j < SLOTS; j++)
			push_op(FUNC_READ, 3'(j), 64'h0);
		push_op(FUNC_ADV, 3'd0, 64'h0);
		push_op(FUNC_NONE, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		push_op(FUNC_NONE, 3'd0, 64'h0);
		settle();
		write_count(4'd1);
		push_op(FUNC_ADV, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		settle();
		write_count(4'd15);
		push_op(FUNC_ADV, 3'd0, 64'h0);
		push_op(FUNC_READ, 3'd5, 64'h0);
		push_op(FUNC_READ, 3'd6, 64'h0);
		push_op(FUNC_READ, 3'd7, 64'h0);

		// random: fixed plan of counts first, then random counts
		foreach (plan[p]) begin
			settle();
			write_count(4'(plan[p]));
			run_phase(plan[p]);
		end
		while (stim_ops < TARGET_OPS) begin
			settle();
			plan[0] = $urandom_range(0, 15);
			write_count(4'(plan[0]));
			run_phase(plan[0]);
		end
		settle();

		if (mismatches == 0)
			$display("next_lexicographic_permutation_top: match");
		else
			$display("next_lexicographic_permutation_top: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("next_lexicographic_permutation_top: mismatch");
		$finish;
	end

endmodule
